// ===== hw/rtl/ltm_pkg.sv =====
// Package for the loop track mode controller.
// Holds the mode, command and action codes, the run record and the mode encoder.
// No dependencies.
package ltm_pkg;

    // Most commands that one input item can cause
    localparam int MaxCmds = 5;
    localparam int CntW    = $clog2(MaxCmds + 1);

    // Track modes, one-hot
    typedef enum logic [5:0] {
        M_IDLE = 6'b000001,
        M_REC  = 6'b000010,
        M_PLAY = 6'b000100,
        M_WAIT = 6'b001000,
        M_OVER = 6'b010000,
        M_STOP = 6'b100000
    } mode_t;

    // Mode codes as seen on the result channel
    localparam logic [2:0] CODE_IDLE = 3'd0;
    localparam logic [2:0] CODE_REC  = 3'd1;
    localparam logic [2:0] CODE_PLAY = 3'd2;
    localparam logic [2:0] CODE_WAIT = 3'd3;
    localparam logic [2:0] CODE_OVER = 3'd4;
    localparam logic [2:0] CODE_STOP = 3'd5;

    // Track commands
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_CONT  = 3'd1,
        CMD_SREC  = 3'd2,
        CMD_EREC  = 3'd3,
        CMD_SPLAY = 3'd4,
        CMD_EPLAY = 3'd5,
        CMD_ABORT = 3'd6
    } cmd_t;

    // Input actions
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_START = 2'd2,
        ACT_RESET = 2'd3
    } action_t;

    // Commands of one input item, first command in slot 0
    typedef struct packed {
        cmd_t [MaxCmds-1:0] cmds;
        logic [CntW-1:0]    cnt;
        logic               adv;
        logic [2:0]         mode_code;
    } run_t;

    // Encode a one-hot mode as its result code
    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] code;
        begin
            case (m)
                M_IDLE:  code = CODE_IDLE;
                M_REC:   code = CODE_REC;
                M_PLAY:  code = CODE_PLAY;
                M_WAIT:  code = CODE_WAIT;
                M_OVER:  code = CODE_OVER;
                M_STOP:  code = CODE_STOP;
                default: code = CODE_IDLE;
            endcase
            return code;
        end
    endfunction

endpackage

// ===== hw/rtl/ltm_step.sv =====
// Mode state and transition logic: turns one registered input item into its command run.
// Depends on ltm_pkg.
module ltm_step
    import ltm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  action_t    action,
    input  logic       button_fell,
    input  logic       loop_boundary,
    input  logic       record_enable,
    input  logic [1:0] first_take_phase,
    output run_t       run
);

    mode_t mode_reg, mode_next;
    mode_t saved_reg, saved_next;
    logic  pend_reg, pend_next;

    // Commit the step when its run is loaded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            saved_reg <= M_IDLE;
            pend_reg  <= 1'b0;
        end else if (load) begin
            mode_reg  <= mode_next;
            saved_reg <= saved_next;
            pend_reg  <= pend_next;
        end
    end

    // Build the command list and next state
    always_comb begin
        cmd_t [MaxCmds-1:0] cmds;
        logic [CntW-1:0]    n;
        logic               adv;
        logic               ph_none;
        logic               ph_rec;
        mode_t              halt_mode;
        logic               halt;

        cmds       = {MaxCmds{CMD_NONE}};
        n          = '0;
        adv        = 1'b0;
        ph_none    = (first_take_phase == 2'd0);
        ph_rec     = (first_take_phase == 2'd1);
        mode_next  = mode_reg;
        saved_next = saved_reg;
        pend_next  = pend_reg;
        halt       = 1'b0;
        halt_mode  = mode_reg;

        case (action)
            ACT_TICK: begin
                pend_next = pend_reg | button_fell;
                // ongoing command of the mode
                if (mode_reg == M_REC || mode_reg == M_OVER) begin
                    cmds[n] = CMD_CONT; n = n + 1'b1;
                end else if (mode_reg == M_PLAY && loop_boundary) begin
                    cmds[n] = CMD_EPLAY; n = n + 1'b1;
                    cmds[n] = CMD_SPLAY; n = n + 1'b1;
                end
                // transition rules
                case (mode_reg)
                    M_IDLE: begin
                        if (pend_next && (ph_none || (record_enable && loop_boundary))) begin
                            cmds[n] = CMD_SREC; n = n + 1'b1;
                            adv       = ph_none;
                            mode_next = M_REC;
                            pend_next = 1'b0;
                        end
                    end
                    M_REC: begin
                        if (pend_next && ph_rec) begin
                            cmds[n] = CMD_EREC; n = n + 1'b1;
                            cmds[n] = CMD_SPLAY; n = n + 1'b1;
                            adv       = 1'b1;
                            mode_next = M_PLAY;
                            pend_next = 1'b0;
                        end else if (loop_boundary) begin
                            cmds[n] = CMD_EREC; n = n + 1'b1;
                            cmds[n] = CMD_SPLAY; n = n + 1'b1;
                            mode_next = M_PLAY;
                        end
                    end
                    M_PLAY: begin
                        if (pend_next && loop_boundary) begin
                            cmds[n] = CMD_EPLAY; n = n + 1'b1;
                            if (record_enable) begin
                                cmds[n] = CMD_SPLAY; n = n + 1'b1;
                                cmds[n] = CMD_SREC; n = n + 1'b1;
                                mode_next = M_OVER;
                            end else begin
                                mode_next = M_WAIT;
                            end
                            pend_next = 1'b0;
                        end
                    end
                    M_WAIT: begin
                        if (pend_next && loop_boundary) begin
                            cmds[n] = CMD_SPLAY; n = n + 1'b1;
                            if (record_enable) begin
                                cmds[n] = CMD_SREC; n = n + 1'b1;
                                mode_next = M_OVER;
                            end else begin
                                mode_next = M_PLAY;
                            end
                            pend_next = 1'b0;
                        end
                    end
                    M_OVER: begin
                        if (loop_boundary) begin
                            cmds[n] = CMD_EREC; n = n + 1'b1;
                            cmds[n] = CMD_SPLAY; n = n + 1'b1;
                            mode_next = M_PLAY;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ACT_STOP: begin
                saved_next = mode_reg;
                halt       = 1'b1;
                mode_next  = M_STOP;
            end
            ACT_START: begin
                if (saved_reg == M_PLAY || saved_reg == M_OVER) begin
                    cmds[n] = CMD_SPLAY; n = n + 1'b1;
                    mode_next = M_PLAY;
                end else if (saved_reg == M_WAIT) begin
                    mode_next = M_WAIT;
                end else begin
                    mode_next = M_IDLE;
                end
            end
            default: begin
                halt      = 1'b1;
                mode_next = M_IDLE;
            end
        endcase

        // drop whatever the mode was doing
        if (halt) begin
            if (halt_mode == M_REC) begin
                cmds[n] = CMD_ABORT; n = n + 1'b1;
            end else if (halt_mode == M_PLAY) begin
                cmds[n] = CMD_EPLAY; n = n + 1'b1;
            end else if (halt_mode == M_OVER) begin
                cmds[n] = CMD_EPLAY; n = n + 1'b1;
                cmds[n] = CMD_ABORT; n = n + 1'b1;
            end
        end

        // an item with no command still gives one result
        if (n == '0) begin
            n = CntW'(1);
        end

        run.cmds      = cmds;
        run.cnt       = n;
        run.adv       = adv;
        run.mode_code = mode_code(mode_next);
    end

endmodule

// ===== hw/rtl/ltm_emit.sv =====
// Result register: holds one command run and shifts it out one item per cycle while m_tready is high.
// Depends on ltm_pkg.
module ltm_emit
    import ltm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  run_t       run,
    output logic       can_load,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    cmd_t [MaxCmds-1:0] cmds_reg;
    logic [CntW-1:0]    cnt_reg;
    logic               adv_reg;
    logic [2:0]         code_reg;
    logic               take;
    logic               last;

    assign take     = m_tvalid && m_tready;
    assign last     = (cnt_reg == CntW'(1));
    assign can_load = (cnt_reg == '0) || (take && last);

    // Count of items left in the run
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= run.cnt;
        end else if (take) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Load a new run or advance to the next command
    always_ff @(posedge aclk) begin
        if (load) begin
            cmds_reg <= run.cmds;
            adv_reg  <= run.adv;
            code_reg <= run.mode_code;
        end else if (take) begin
            cmds_reg <= {CMD_NONE, cmds_reg[MaxCmds-1:1]};
        end
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tlast  = last;
    assign m_tdata  = {1'b0, code_reg, adv_reg & last, cmds_reg[0]};

endmodule

// ===== hw/rtl/loop_track_mode_controller.sv =====
// Top level of the loop track mode controller: input register, step logic, result register.
// Depends on ltm_pkg, ltm_step and ltm_emit.
//
//   channel | dir | payload
//   s_      | in  | tuser: action; tdata: button_fell, loop_boundary, record_enable,
//           |     |        first_take_phase
//   m_      | out | tdata: command, advance_phase, mode_now; tlast: last
//
// An item causes one to five commands. The result register sends one command per
// cycle while m_tready is high. Items with a single result flow at one per cycle
// while m_tready is high. One input item waits in the input register while a run drains.
// Reset (aresetn low at a clock edge) returns the mode and the saved mode to idle,
// clears the pending press and drops any item or run in flight.
// Stalls on m_tready hold the run; s_tready falls once the input register is full.
module loop_track_mode_controller
    import ltm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    // [1:0] action
    input  logic [1:0] s_tuser,
    // [0] button_fell, [1] loop_boundary, [2] record_enable,
    // [4:3] first_take_phase, [7:5] zero
    input  logic [7:0] s_tdata,
    output logic       m_tvalid,
    input  logic       m_tready,
    // [2:0] command, [3] advance_phase, [6:4] mode_now, [7] zero
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic       in_vld_reg;
    logic [6:0] in_data_reg;
    logic       can_load;
    logic       load;
    run_t       run;

    assign load     = in_vld_reg && can_load;
    assign s_tready = !in_vld_reg || load;

    // Hold the input item until its run is loaded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= {s_tdata[4:0], s_tuser};
        end
    end

    ltm_step u_step (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (load),
        .action           (action_t'(in_data_reg[1:0])),
        .button_fell      (in_data_reg[2]),
        .loop_boundary    (in_data_reg[3]),
        .record_enable    (in_data_reg[4]),
        .first_take_phase (in_data_reg[6:5]),
        .run              (run)
    );

    ltm_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .run      (run),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
